/* rtl/core/gaze_direction_key_qualifier_assert.svh */
// Assertion macros for the gaze direction key qualifier
`ifndef GAZE_DIRECTION_KEY_QUALIFIER_ASSERT_SVH
`define GAZE_DIRECTION_KEY_QUALIFIER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define GDKQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GDKQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gdkq_pkg.sv */
`default_nettype none

package gdkq_pkg;

  localparam int unsigned COORD_W      = 14;
  localparam int unsigned COOLDOWN_W   = 16;
  localparam int unsigned ELAPSED_W    = 16;
  localparam int unsigned RUN_W        = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned DIR_W        = 2;
  localparam int unsigned SUM_W        = COORD_W + 3;

  localparam int unsigned ACTIVATION_FRAMES_DEF = 3;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  localparam logic [COORD_W-1:0]    HORIZ_THR_RST = COORD_W'(240);
  localparam logic [COORD_W-1:0]    VERT_THR_RST  = COORD_W'(128);
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST  = COOLDOWN_W'(500);

  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEFT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEFT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RIGHT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RIGHT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_THR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_THR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd7;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic                calibrated;
    logic [COORD_W-1:0]  base_left_x;
    logic [COORD_W-1:0]  base_left_y;
    logic [COORD_W-1:0]  base_right_x;
    logic [COORD_W-1:0]  base_right_y;
    logic [COORD_W-1:0]  horiz_thr;
    logic [COORD_W-1:0]  vert_thr;
  } front_cfg_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic is_tick;
    logic is_sample;
    logic up;
    logic down;
    logic left;
    logic right;
  } cls_t;

  typedef struct packed {
    logic fire;
    dir_e dir;
    logic suppressed;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/gdkq_fifo.sv */
`default_nettype none

module gdkq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gdkq_front.sv */
`default_nettype none

module gdkq_front (
  input  wire gdkq_pkg::front_cfg_t           cfg_i,
  input  wire logic                           command_i,
  input  wire logic                           left_valid_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]   left_x_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]   left_y_i,
  input  wire logic                           right_valid_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]   right_x_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]   right_y_i,
  output gdkq_pkg::cls_t                      cls_o
);

  logic signed [gdkq_pkg::SUM_W-1:0] sum_x, sum_y, lim_x, lim_y;

  // sum of both eyes' offsets against twice the threshold: exact average test
  assign sum_x = $signed({3'b000, left_x_i}) - $signed({3'b000, cfg_i.base_left_x})
               + $signed({3'b000, right_x_i}) - $signed({3'b000, cfg_i.base_right_x});
  assign sum_y = $signed({3'b000, left_y_i}) - $signed({3'b000, cfg_i.base_left_y})
               + $signed({3'b000, right_y_i}) - $signed({3'b000, cfg_i.base_right_y});
  assign lim_x = $signed({2'b00, cfg_i.horiz_thr, 1'b0});
  assign lim_y = $signed({2'b00, cfg_i.vert_thr, 1'b0});

  always_comb begin
    cls_o.is_tick   = command_i;
    cls_o.is_sample = !command_i && cfg_i.calibrated && left_valid_i && right_valid_i;
    cls_o.up        = sum_y < -lim_y;
    cls_o.down      = sum_y > lim_y;
    cls_o.left      = sum_x < -lim_x;
    cls_o.right     = sum_x > lim_x;
  end

endmodule

`default_nettype wire

/* rtl/core/gdkq_back.sv */
`default_nettype none

module gdkq_back #(
  parameter int unsigned ACTIVATION_FRAMES = gdkq_pkg::ACTIVATION_FRAMES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [gdkq_pkg::COOLDOWN_W-1:0]   cooldown_i,
  input  wire logic                              cls_avail_i,
  input  wire gdkq_pkg::cls_t                    cls_i,
  output logic                                   cls_take_o,
  input  wire logic                              res_full_i,
  output logic                                   res_push_o,
  output gdkq_pkg::res_t                         res_o
);

  localparam logic [gdkq_pkg::RUN_W-1:0] ACT = gdkq_pkg::RUN_W'(ACTIVATION_FRAMES);

  logic [gdkq_pkg::RUN_W-1:0]     up_q, down_q, left_q, right_q;
  logic [gdkq_pkg::RUN_W-1:0]     up_d, down_d, left_d, right_d;
  logic [gdkq_pkg::RUN_W-1:0]     up_b, down_b, left_b, right_b;
  logic [gdkq_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                           qualified;

  function automatic logic [gdkq_pkg::RUN_W-1:0] bump(
    input logic [gdkq_pkg::RUN_W-1:0] run,
    input logic                       moved
  );
    logic [gdkq_pkg::RUN_W-1:0] r;
    if (!moved) begin
      r = '0;
    end else if (run >= ACT) begin
      r = ACT;
    end else begin
      r = run + gdkq_pkg::RUN_W'(1);
    end
    return r;
  endfunction

  assign cls_take_o = cls_avail_i && !res_full_i;
  assign res_push_o = cls_take_o;

  always_comb begin
    up_b      = bump(up_q, cls_i.up);
    down_b    = bump(down_q, cls_i.down);
    left_b    = bump(left_q, cls_i.left);
    right_b   = bump(right_q, cls_i.right);
    up_d      = up_q;
    down_d    = down_q;
    left_d    = left_q;
    right_d   = right_q;
    elapsed_d = elapsed_q;
    qualified = 1'b0;
    res_o     = '{fire: 1'b0, dir: gdkq_pkg::DIR_UP, suppressed: 1'b0};

    if (cls_i.is_tick) begin
      if (elapsed_q != '1) begin
        elapsed_d = elapsed_q + gdkq_pkg::ELAPSED_W'(1);
      end
    end else if (cls_i.is_sample) begin
      up_d    = up_b;
      down_d  = down_b;
      left_d  = left_b;
      right_d = right_b;
      // fixed priority up, down, left, right
      if (up_b >= ACT) begin
        qualified = 1'b1;
        res_o.dir = gdkq_pkg::DIR_UP;
        up_d      = '0;
      end else if (down_b >= ACT) begin
        qualified = 1'b1;
        res_o.dir = gdkq_pkg::DIR_DOWN;
        down_d    = '0;
      end else if (left_b >= ACT) begin
        qualified = 1'b1;
        res_o.dir = gdkq_pkg::DIR_LEFT;
        left_d    = '0;
      end else if (right_b >= ACT) begin
        qualified = 1'b1;
        res_o.dir = gdkq_pkg::DIR_RIGHT;
        right_d   = '0;
      end
      if (qualified) begin
        if (elapsed_q >= cooldown_i) begin
          res_o.fire = 1'b1;
          elapsed_d  = '0;
        end else begin
          res_o.suppressed = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q      <= '0;
      down_q    <= '0;
      left_q    <= '0;
      right_q   <= '0;
      elapsed_q <= '0;
    end else if (cls_take_o) begin
      up_q      <= up_d;
      down_q    <= down_d;
      left_q    <= left_d;
      right_q   <= right_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gaze_direction_key_qualifier.sv */
// Gaze direction key qualifier. Takes one transaction per clock while not full on the
// push/full side (a pupil sample or a one-millisecond tick) and returns exactly one
// result per transaction, in order, on the empty/pop side. The front classifies each
// sample against the baselines and thresholds in the accepting cycle and writes it
// into a short queue; the back drains that queue at one entry per cycle while the
// output queue is not full, updating the run and cooldown counters, and writes the
// result into the output queue, from which it is visible. Sustained rate is one
// transaction per cycle while results are popped. The user must write registers only
// while no transaction is in flight; the block itself does not enforce this.
`default_nettype none

`include "gaze_direction_key_qualifier_assert.svh"

module gaze_direction_key_qualifier #(
  parameter int unsigned ACTIVATION_FRAMES = gdkq_pkg::ACTIVATION_FRAMES_DEF,
  parameter int unsigned QUEUE_DEPTH       = gdkq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gdkq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [gdkq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              command_i,
  input  wire logic                              left_valid_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]      left_x_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]      left_y_i,
  input  wire logic                              right_valid_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]      right_x_i,
  input  wire logic [gdkq_pkg::COORD_W-1:0]      right_y_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   key_fire_o,
  output logic [gdkq_pkg::DIR_W-1:0]             key_direction_o,
  output logic                                   key_suppressed_o
);

  gdkq_pkg::front_cfg_t             cfg_q;
  logic [gdkq_pkg::COOLDOWN_W-1:0]  cooldown_q;
  logic [gdkq_pkg::COORD_W-1:0]     cfg_coord;

  gdkq_pkg::cls_t cls_in, cls_out;
  gdkq_pkg::res_t res_in, res_out;
  logic           cq_full, cq_empty, cq_take;
  logic           rq_full, rq_push;

  assign cfg_coord = cfg_data_i[gdkq_pkg::COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibrated   <= 1'b0;
      cfg_q.base_left_x  <= '0;
      cfg_q.base_left_y  <= '0;
      cfg_q.base_right_x <= '0;
      cfg_q.base_right_y <= '0;
      cfg_q.horiz_thr    <= gdkq_pkg::HORIZ_THR_RST;
      cfg_q.vert_thr     <= gdkq_pkg::VERT_THR_RST;
      cooldown_q         <= gdkq_pkg::COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gdkq_pkg::REG_CALIBRATED:   cfg_q.calibrated   <= cfg_data_i[0];
        gdkq_pkg::REG_BASE_LEFT_X:  cfg_q.base_left_x  <= cfg_coord;
        gdkq_pkg::REG_BASE_LEFT_Y:  cfg_q.base_left_y  <= cfg_coord;
        gdkq_pkg::REG_BASE_RIGHT_X: cfg_q.base_right_x <= cfg_coord;
        gdkq_pkg::REG_BASE_RIGHT_Y: cfg_q.base_right_y <= cfg_coord;
        gdkq_pkg::REG_HORIZ_THR:    cfg_q.horiz_thr    <= cfg_coord;
        gdkq_pkg::REG_VERT_THR:     cfg_q.vert_thr     <= cfg_coord;
        gdkq_pkg::REG_COOLDOWN:     cooldown_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gdkq_front u_front (
    .cfg_i         (cfg_q),
    .command_i     (command_i),
    .left_valid_i  (left_valid_i),
    .left_x_i      (left_x_i),
    .left_y_i      (left_y_i),
    .right_valid_i (right_valid_i),
    .right_x_i     (right_x_i),
    .right_y_i     (right_y_i),
    .cls_o         (cls_in)
  );

  gdkq_fifo #(
    .WIDTH ($bits(gdkq_pkg::cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (cls_in),
    .full_o    (cq_full),
    .rd_en_i   (cq_take),
    .rd_data_o (cls_out),
    .empty_o   (cq_empty)
  );

  gdkq_back #(
    .ACTIVATION_FRAMES (ACTIVATION_FRAMES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cooldown_i  (cooldown_q),
    .cls_avail_i (!cq_empty),
    .cls_i       (cls_out),
    .cls_take_o  (cq_take),
    .res_full_i  (rq_full),
    .res_push_o  (rq_push),
    .res_o       (res_in)
  );

  gdkq_fifo #(
    .WIDTH ($bits(gdkq_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rq_push),
    .wr_data_i (res_in),
    .full_o    (rq_full),
    .rd_en_i   (pop),
    .rd_data_o (res_out),
    .empty_o   (empty)
  );

  assign full             = cq_full;
  assign key_fire_o       = res_out.fire;
  assign key_direction_o  = res_out.dir;
  assign key_suppressed_o = res_out.suppressed;

  `GDKQ_ASSERT(a_fire_xor_supp, !(!empty && key_fire_o && key_suppressed_o),
    "key fired and suppressed in one result")
  `GDKQ_ASSERT(a_idle_dir_zero,
    !(!empty && !key_fire_o && !key_suppressed_o && key_direction_o != gdkq_pkg::DIR_UP),
    "direction set on a result without a qualified key")
  `GDKQ_ASSERT_NEXT(a_push_lands, push && !full, !cq_empty,
    "accepted transaction missing from classification queue")
  `GDKQ_ASSERT_NEXT(a_take_lands, cq_take, !empty,
    "executed transaction missing from result queue")

endmodule

`default_nettype wire
